FILE: rtl/ghst_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle slot table package
// Operation codes, status codes and controller states of the core; its
// checker uses the status codes as well.
// ----------------------------------------------------------------------------
package ghst_pkg;

    localparam int FUNC_W   = 2;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int HANDLE_W = 10;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 10;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_LOOKUP  = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_BAD     = 2'd1,
        STAT_FULL    = 2'd2,
        STAT_MISSING = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    localparam logic [KIND_W-1:0] KIND_INVALID = '0;

endpackage

FILE: rtl/ghst_slot_ram.sv
// ----------------------------------------------------------------------------
// Slot entry memory
// Single-port-write, single-port-read synchronous memory with a registered
// read.
// ----------------------------------------------------------------------------
module ghst_slot_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 76,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/generational_handle_slot_table_core.sv
// ----------------------------------------------------------------------------
// Generational handle slot table core
// Hands out slot handles from a free list threaded through the slot entries,
// or else from slots not used yet, with lookup and release of live handles.
// ----------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. In the accept
// cycle the slot entry is read from the entry memory, and in the following
// cycle, while busy is high, the entry is checked and written back. The result
// appears for one cycle with done high in the cycle after that, and a new
// transaction may be started in that same cycle; no new transaction is taken
// while busy is high. The receiver cannot stall results. Entries of slots at
// or above the count of slots used so far are never used, so no clearing
// pass runs after reset and the block is ready at once.
module generational_handle_slot_table_core
    import ghst_pkg::*;
#(
    parameter int SLOT_CAPACITY = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FUNC_W-1:0]   func,
    input  logic [KIND_W-1:0]   kind,
    input  logic [WORD_W-1:0]   payload_index,
    input  logic [WORD_W-1:0]   payload_generation,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [HANDLE_W-1:0] slot,
    output logic [KIND_W-1:0]   entry_kind,
    output logic [WORD_W-1:0]   entry_index,
    output logic [WORD_W-1:0]   entry_generation,
    output logic [COUNT_W-1:0]  live_entries
);

    localparam int AW     = $clog2(SLOT_CAPACITY);
    localparam int UW     = $clog2(SLOT_CAPACITY + 1);
    localparam int CMPW   = (UW > HANDLE_W) ? UW : HANDLE_W;
    localparam int ENTRYW = KIND_W + 2 * WORD_W + AW;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] idx;
        logic [WORD_W-1:0] gen;
        logic [AW-1:0]     next_free;
    } slot_entry_t;

    state_t state_reg, state_next;

    logic [FUNC_W-1:0]   func_reg;
    logic [KIND_W-1:0]   kind_reg;
    logic [WORD_W-1:0]   idx_reg;
    logic [WORD_W-1:0]   gen_reg;
    logic [HANDLE_W-1:0] handle_reg;

    logic [UW-1:0] used_reg, used_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] live_reg, live_next;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [HANDLE_W-1:0] slot_reg;
    logic [KIND_W-1:0]   ekind_reg;
    logic [WORD_W-1:0]   eidx_reg;
    logic [WORD_W-1:0]   egen_reg;
    logic [COUNT_W-1:0]  live_out_reg;

    logic          accept;
    logic          exec;
    logic [AW-1:0] rd_addr;
    logic [ENTRYW-1:0] rd_word;
    slot_entry_t   rd_entry;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    slot_entry_t   wr_entry;

    status_t       res_status;
    logic [AW-1:0] res_slot;
    logic [KIND_W-1:0] res_kind;
    logic [WORD_W-1:0] res_idx;
    logic [WORD_W-1:0] res_gen;
    logic          handle_live;

    assign accept   = start && !busy;
    assign rd_addr  = (func_t'(func) == FUNC_ALLOC) ? head_reg : AW'(handle);
    assign rd_entry = slot_entry_t'(rd_word);

    ghst_slot_ram #(
        .DEPTH  (SLOT_CAPACITY),
        .DATA_W (ENTRYW),
        .ADDR_W (AW)
    ) u_slot_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (ENTRYW'(wr_entry))
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = 1'b0;
        exec = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
            ST_EXEC:
            begin
                busy = 1'b1;
                exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                exec = 1'b0;
            end
        endcase
    end

    assign handle_live = (handle_reg != '0)
                      && (CMPW'(handle_reg) < CMPW'(used_reg))
                      && (rd_entry.kind != KIND_INVALID);

    always_comb
    begin
        used_next  = used_reg;
        head_next  = head_reg;
        live_next  = live_reg;
        wr_en      = 1'b0;
        wr_addr    = AW'(handle_reg);
        wr_entry   = '0;
        res_status = STAT_BAD;
        res_slot   = '0;
        res_kind   = '0;
        res_idx    = '0;
        res_gen    = '0;
        unique case (func_t'(func_reg))
            FUNC_ALLOC:
            begin
                if ((kind_reg != KIND_INVALID) && (gen_reg != '0))
                begin
                    wr_entry.kind = kind_reg;
                    wr_entry.idx  = idx_reg;
                    wr_entry.gen  = gen_reg;
                    if (head_reg != '0)
                    begin
                        wr_en      = exec;
                        wr_addr    = head_reg;
                        head_next  = rd_entry.next_free;
                        live_next  = AW'(live_reg + 1'b1);
                        res_status = STAT_OK;
                        res_slot   = head_reg;
                    end
                    else if (used_reg < UW'(SLOT_CAPACITY))
                    begin
                        wr_en      = exec;
                        wr_addr    = AW'(used_reg);
                        used_next  = UW'(used_reg + 1'b1);
                        live_next  = AW'(live_reg + 1'b1);
                        res_status = STAT_OK;
                        res_slot   = AW'(used_reg);
                    end
                    else
                    begin
                        res_status = STAT_FULL;
                    end
                end
            end
            FUNC_LOOKUP:
            begin
                if (handle_live)
                begin
                    res_status = STAT_OK;
                    res_slot   = AW'(handle_reg);
                    res_kind   = rd_entry.kind;
                    res_idx    = rd_entry.idx;
                    res_gen    = rd_entry.gen;
                end
                else
                begin
                    res_status = STAT_MISSING;
                end
            end
            FUNC_RELEASE:
            begin
                if (handle_live)
                begin
                    wr_en              = exec;
                    wr_entry.next_free = head_reg;
                    head_next          = AW'(handle_reg);
                    if (live_reg != '0)
                    begin
                        live_next = AW'(live_reg - 1'b1);
                    end
                    res_status = STAT_OK;
                    res_slot   = AW'(handle_reg);
                end
                else
                begin
                    res_status = STAT_MISSING;
                end
            end
            default:
            begin
                res_status = STAT_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= UW'(1);
            head_reg  <= '0;
            live_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                used_reg <= used_next;
                head_reg <= head_next;
                live_reg <= live_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            kind_reg   <= kind;
            idx_reg    <= payload_index;
            gen_reg    <= payload_generation;
            handle_reg <= handle;
        end
        if (exec)
        begin
            status_reg   <= res_status;
            slot_reg     <= HANDLE_W'(res_slot);
            ekind_reg    <= res_kind;
            eidx_reg     <= res_idx;
            egen_reg     <= res_gen;
            live_out_reg <= COUNT_W'(live_next);
        end
    end

    assign done             = done_reg;
    assign status           = status_reg;
    assign slot             = slot_reg;
    assign entry_kind       = ekind_reg;
    assign entry_index      = eidx_reg;
    assign entry_generation = egen_reg;
    assign live_entries     = live_out_reg;

endmodule

FILE: rtl/ghst_checker.sv
// ----------------------------------------------------------------------------
// Generational handle slot table checker
// Port-level assertions on transaction timing and result consistency, bound
// to the core.
// ----------------------------------------------------------------------------
module ghst_checker
    import ghst_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [STATUS_W-1:0] status,
    input logic [HANDLE_W-1:0] slot,
    input logic [KIND_W-1:0]   entry_kind,
    input logic [WORD_W-1:0]   entry_index,
    input logic [WORD_W-1:0]   entry_generation
);

    // Every accepted transaction is followed by busy and then by its result.
    a_result_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy ##1 done
    ) else $error("result did not follow an accepted transaction");

    // A result is only produced after a busy cycle, and the core is free then.
    a_done_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy))
    ) else $error("result strobe without a preceding busy cycle");

    // A failed transaction never reports a slot.
    a_fail_null_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |-> (slot == '0)
    ) else $error("failed transaction reported a nonzero slot");

    // A failed transaction never reports entry contents.
    a_fail_no_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && (status != STAT_OK)) |->
            ((entry_kind == '0) && (entry_index == '0) && (entry_generation == '0))
    ) else $error("failed transaction reported entry contents");

endmodule

bind generational_handle_slot_table_core ghst_checker u_ghst_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .status           (status),
    .slot             (slot),
    .entry_kind       (entry_kind),
    .entry_index      (entry_index),
    .entry_generation (entry_generation)
);
